// ===== hdl/fpr_pkg.sv =====
// ---------------------------------------------------------------------------
// fpr_pkg: shared types and helpers for the framed packet receiver
// Status codes, register map, result record and the CRC-16 byte update.
// ---------------------------------------------------------------------------
package fpr_pkg;

   localparam int BYTE_W   = 8;
   localparam int CRC_W    = 16;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from the word address bit of paddr
   localparam logic REG_START_BYTE  = 1'b0;
   localparam logic REG_MAX_PAYLOAD = 1'b1;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'd126;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd255;

   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 3;

   typedef struct packed {
      logic [CRC_W-1:0]    received_crc;
      logic [CRC_W-1:0]    computed_crc;
      logic [BYTE_W-1:0]   payload_index;
      logic [BYTE_W-1:0]   payload_byte;
      logic                payload_valid;
      logic [BYTE_W-1:0]   length;
      logic [BYTE_W-1:0]   command;
      logic [STATUS_W-1:0] status;
   } result_type;

   // CRC-16/CCITT-FALSE, MSB first, one byte
   function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0]  crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/framed_packet_receiver_crc16.sv =====
// ---------------------------------------------------------------------------
// framed_packet_receiver_crc16: byte-stream frame receiver with CRC-16 check
// Frame: start byte, command, length, payload, CRC-16/CCITT-FALSE (big endian).
//
// req channel: one received byte per beat in req_tdata[7:0].
// rsp channel: one result beat per req beat, in order; status and
//   payload_valid in rsp_tuser, command/length/payload/CRCs in rsp_tdata.
// csr port: APB-style; start_byte at 0x0, max_payload at 0x4. Write only
//   while the stream is idle. pready is tied high.
// Output: every result is registered before it is presented on rsp.
// Throughput: one byte per cycle while req_tready is high; the CRC byte
//   update and the parser step are combinational, feeding the result register.
// Stall: a skid stage holds one extra result, so req_tready drops only
//   once two results are waiting on rsp.
// Reset: parser goes to hunting, CRC to 0xFFFF, counters cleared,
//   registers to start_byte 0x7E and max_payload 0xFF, rsp empty.
// ---------------------------------------------------------------------------
module framed_packet_receiver_crc16 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] command, [15:8] length, [23:16] payload_byte,
   // [31:24] payload_index, [47:32] computed_crc, [63:48] received_crc
   output logic [fpr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [fpr_pkg::RSP_USER_W-1:0]  rsp_tuser,  // [1:0] status, [2] payload_valid
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fpr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fpr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fpr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import fpr_pkg::*;

   logic [BYTE_W-1:0] start_byte_ff, max_payload_ff;
   logic              csr_write;
   logic              req_beat;
   result_type        parse_result;
   result_type        rsp_result;

   // ---- configuration registers ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_START_BYTE:  start_byte_ff  <= csr_pwdata[BYTE_W-1:0];
            REG_MAX_PAYLOAD: max_payload_ff <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_START_BYTE:  csr_prdata[BYTE_W-1:0] = start_byte_ff;
         REG_MAX_PAYLOAD: csr_prdata[BYTE_W-1:0] = max_payload_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // ---- datapath ----
   assign req_beat = req_tvalid && req_tready;

   fpr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat        (req_beat),
      .rx_byte     (req_tdata),
      .start_byte  (start_byte_ff),
      .max_payload (max_payload_ff),
      .result      (parse_result)
   );

   fpr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {rsp_result.received_crc, rsp_result.computed_crc,
                       rsp_result.payload_index, rsp_result.payload_byte,
                       rsp_result.length, rsp_result.command};
   assign rsp_tuser = {rsp_result.payload_valid, rsp_result.status};

   // ---- assertions ----
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled while rsp side is empty");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp beat presented right after reset");

   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == STATUS_BUSY)
      else $error("payload beat carries a final status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("undefined status code on rsp");

endmodule

// ===== hdl/fpr_parser.sv =====
// ---------------------------------------------------------------------------
// fpr_parser: frame parser state machine
// Steps the frame state on every accepted byte and forms that beat's result.
// ---------------------------------------------------------------------------
module fpr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             start_byte,
   input  logic [7:0]             max_payload,
   output fpr_pkg::result_type    result
);
   import fpr_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAY  = 3'd3,
      PH_CRC  = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [CRC_W-1:0]  got_ff, got_in;
   logic              crc_cnt_ff, crc_cnt_in;
   logic [CRC_W-1:0]  crc_fed;
   logic              finish;

   assign crc_fed = crc16_feed(crc_ff, rx_byte);

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      got_in     = got_ff;
      crc_cnt_in = crc_cnt_ff;
      finish     = 1'b0;
      result     = '0;
      result.status = STATUS_BUSY;

      case (phase_ff)
         PH_CMD: begin
            cmd_in   = rx_byte;
            crc_in   = crc_fed;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = rx_byte;
            crc_in   = crc_fed;
            phase_in = (rx_byte == '0) ? PH_CRC : PH_PAY;
         end
         PH_PAY: begin
            if (count_ff >= max_payload) begin
               result.status = STATUS_ERR;
               finish        = 1'b1;
            end else begin
               result.payload_valid = 1'b1;
               result.payload_byte  = rx_byte;
               result.payload_index = count_ff;
               crc_in   = crc_fed;
               count_in = count_ff + 8'd1;
               if (count_in == len_ff) begin
                  phase_in = PH_CRC;
               end
            end
         end
         PH_CRC: begin
            if (!crc_cnt_ff) begin
               got_in     = {rx_byte, 8'h00};
               crc_cnt_in = 1'b1;
            end else begin
               got_in        = got_ff | {8'h00, rx_byte};
               result.status = (got_in == crc_ff) ? STATUS_DONE : STATUS_ERR;
               finish        = 1'b1;
            end
         end
         default: begin
            phase_in = (rx_byte == start_byte) ? PH_CMD : PH_HUNT;
         end
      endcase

      // result shows the values before the end-of-frame clear
      result.command      = cmd_in;
      result.length       = len_in;
      result.computed_crc = crc_in;
      result.received_crc = got_in;

      if (finish) begin
         phase_in   = PH_HUNT;
         count_in   = '0;
         crc_cnt_in = 1'b0;
         got_in     = '0;
         crc_in     = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         cmd_ff     <= '0;
         len_ff     <= '0;
         count_ff   <= '0;
         crc_ff     <= CRC_INIT;
         got_ff     <= '0;
         crc_cnt_ff <= 1'b0;
      end else if (beat) begin
         phase_ff   <= phase_in;
         cmd_ff     <= cmd_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         got_ff     <= got_in;
         crc_cnt_ff <= crc_cnt_in;
      end
   end

endmodule

// ===== hdl/fpr_out_buf.sv =====
// ---------------------------------------------------------------------------
// fpr_out_buf: result register with skid stage
// Holds results for the rsp side; under stall the skid stage takes one more before in_ready drops.
// ---------------------------------------------------------------------------
module fpr_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  fpr_pkg::result_type    in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fpr_pkg::result_type    out_data
);
   import fpr_pkg::*;

   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;
   logic       push, pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (pop || !out_valid_ff) begin
         out_valid_ff <= push;
         if (push) begin
            out_data_ff <= in_data;
         end
      end else if (push) begin
         skid_data_ff  <= in_data;
         skid_valid_ff <= 1'b1;
      end
   end

endmodule

// ===== dv/framed_packet_receiver_crc16_tb.sv =====
// ---------------------------------------------------------------------------
// framed_packet_receiver_crc16_tb: self-checking bench for the frame receiver
// Feeds byte streams of well-formed, corrupted, truncated and overlong frames
// through the req channel and checks every rsp beat against a cycle-free
// parser model kept in the bench, over several start_byte and max_payload
// settings and with random sender gaps on req and back-pressure on rsp.
// ---------------------------------------------------------------------------
module framed_packet_receiver_crc16_tb;
   import fpr_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int LONG_HOLD      = 300;
   localparam int PRESSURE_PHASE = 4;

   localparam logic [CSR_ADDR_W-1:0] ADDR_START_BYTE  = {REG_START_BYTE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};

   typedef enum logic [2:0] {
      PRS_HUNT,
      PRS_CMD,
      PRS_LEN,
      PRS_PAY,
      PRS_CRC
   } prs_phase_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   command;
      logic [BYTE_W-1:0]   length;
      logic                pay_valid;
      logic [BYTE_W-1:0]   pay_byte;
      logic [BYTE_W-1:0]   pay_index;
      logic [CRC_W-1:0]    crc_comp;
      logic [CRC_W-1:0]    crc_rcvd;
   } rx_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;       // [7:0] rx_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] command, [15:8] length, [23:16] payload_byte,
   // [31:24] payload_index, [47:32] computed_crc, [63:48] received_crc
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;            // [1:0] status, [2] payload_valid
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   framed_packet_receiver_crc16 dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // parser model state and its copy of the registers
   logic [BYTE_W-1:0] cfg_start_byte  = START_BYTE_RESET;
   logic [BYTE_W-1:0] cfg_max_payload = MAX_PAYLOAD_RESET;
   prs_phase_type     prs_phase    = PRS_HUNT;
   logic [BYTE_W-1:0] prs_cmd      = '0;
   logic [BYTE_W-1:0] prs_len      = '0;
   logic [BYTE_W-1:0] prs_count    = '0;
   logic [CRC_W-1:0]  prs_crc      = CRC_INIT;
   logic [CRC_W-1:0]  prs_got      = '0;
   logic              prs_crc_half = 1'b0;

   logic [7:0]     pending_bytes[$];
   rx_result_type  expected_results[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int phase_num      = 0;
   int hold_left      = 0;
   bit long_hold_done = 1'b0;
   int cycle_count    = 0;
   int mismatches     = 0;
   int beats_sent     = 0;
   int good_frames    = 0;
   int err_reports    = 0;
   int payload_beats  = 0;

   logic          offer_next;
   logic          ready_next;
   rx_result_type got_res;
   rx_result_type want_res;

   function automatic logic [CRC_W-1:0] crc_ccitt_byte(input logic [CRC_W-1:0]  crc,
                                                       input logic [BYTE_W-1:0] d);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ d[i];
         c  = {c[CRC_W-2:0], 1'b0};
         if (fb) begin
            c = c ^ 16'h1021;
         end
      end
      return c;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      rx_result_type r;
      logic          close;
      r        = '0;
      r.status = STATUS_BUSY;
      close    = 1'b0;
      case (prs_phase)
         PRS_CMD: begin
            prs_cmd   = b;
            prs_crc   = crc_ccitt_byte(prs_crc, b);
            prs_phase = PRS_LEN;
         end
         PRS_LEN: begin
            prs_len   = b;
            prs_crc   = crc_ccitt_byte(prs_crc, b);
            prs_phase = (b == 8'd0) ? PRS_CRC : PRS_PAY;
         end
         PRS_PAY: begin
            if (prs_count >= cfg_max_payload) begin
               r.status = STATUS_ERR;
               close    = 1'b1;
            end else begin
               r.pay_valid = 1'b1;
               r.pay_byte  = b;
               r.pay_index = prs_count;
               prs_crc     = crc_ccitt_byte(prs_crc, b);
               prs_count   = prs_count + 8'd1;
               if (prs_count == prs_len) begin
                  prs_phase = PRS_CRC;
               end
            end
         end
         PRS_CRC: begin
            if (!prs_crc_half) begin
               prs_got      = {b, 8'h00};
               prs_crc_half = 1'b1;
            end else begin
               prs_got[7:0] = b;
               r.status     = (prs_got == prs_crc) ? STATUS_DONE : STATUS_ERR;
               close        = 1'b1;
            end
         end
         default: begin
            prs_phase = (b == cfg_start_byte) ? PRS_CMD : PRS_HUNT;
         end
      endcase
      r.command  = prs_cmd;
      r.length   = prs_len;
      r.crc_comp = prs_crc;
      r.crc_rcvd = prs_got;
      expected_results.push_back(r);
      if (close) begin
         prs_phase    = PRS_HUNT;
         prs_count    = '0;
         prs_crc_half = 1'b0;
         prs_got      = '0;
         prs_crc      = CRC_INIT;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      end
   endtask

   // fill: -1 for random payload; keep: -1 for the whole frame
   task automatic push_frame(input logic [7:0] cmd, input int len, input bit bad_crc,
                             input int fill, input int keep);
      logic [CRC_W-1:0] c;
      logic [7:0]       d;
      logic [7:0]       frame[$];
      frame = {};
      frame.push_back(cfg_start_byte);
      frame.push_back(cmd);
      frame.push_back(len[7:0]);
      c = crc_ccitt_byte(CRC_INIT, cmd);
      c = crc_ccitt_byte(c, len[7:0]);
      for (int i = 0; i < len; i++) begin
         d = (fill < 0) ? 8'($urandom) : fill[7:0];
         frame.push_back(d);
         c = crc_ccitt_byte(c, d);
      end
      if (bad_crc) begin
         c = c ^ (16'd1 << $urandom_range(15));
      end
      frame.push_back(c[15:8]);
      frame.push_back(c[7:0]);
      while (keep >= 0 && frame.size() > keep) begin
         void'(frame.pop_back());
      end
      foreach (frame[i]) begin
         pending_bytes.push_back(frame[i]);
      end
   endtask

   task automatic gen_link_traffic(input int n);
      int target;
      int r;
      int len;
      int cap;
      int hi;
      target = pending_bytes.size() + n;
      cap    = (cfg_max_payload < 12) ? cfg_max_payload : 12;
      while (pending_bytes.size() < target) begin
         r   = $urandom_range(99);
         len = ($urandom_range(59) == 0) ? $urandom_range(cfg_max_payload) : $urandom_range(cap);
         if (r < 8) begin
            repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
         end else if (r < 78) begin
            push_frame(8'($urandom), len, 1'b0, -1, -1);
         end else if (r < 88) begin
            push_frame(8'($urandom), len, 1'b1, -1, -1);
         end else if (r < 94) begin
            push_frame(8'($urandom), len, 1'b0, -1, $urandom_range(1, len + 4));
         end else if (cfg_max_payload < 8'd255) begin
            hi = (cfg_max_payload + 6 > 255) ? 255 : cfg_max_payload + 6;
            push_frame(8'($urandom), $urandom_range(cfg_max_payload + 1, hi), 1'b0, -1, -1);
         end else begin
            push_frame(8'($urandom), len, 1'b0, -1, -1);
         end
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_START_BYTE) begin
         cfg_start_byte = val;
      end else if (addr == ADDR_MAX_PAYLOAD) begin
         cfg_max_payload = val;
      end
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr readback", {8'd0, val}, {8'd0, csr_prdata[7:0]});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            offer_next = pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (offer_next) begin
               req_tdata <= pending_bytes.pop_front();
            end
            req_tvalid <= offer_next;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (phase_num == PRESSURE_PHASE && !long_hold_done) begin
         hold_left      <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_res.status    = rsp_tuser[1:0];
            got_res.pay_valid = rsp_tuser[2];
            got_res.command   = rsp_tdata[7:0];
            got_res.length    = rsp_tdata[15:8];
            got_res.pay_byte  = rsp_tdata[23:16];
            got_res.pay_index = rsp_tdata[31:24];
            got_res.crc_comp  = rsp_tdata[47:32];
            got_res.crc_rcvd  = rsp_tdata[63:48];
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat expected none, got 0x%0h",
                        $time, got_res);
            end else begin
               want_res = expected_results.pop_front();
               check_field("status", 16'(want_res.status), 16'(got_res.status));
               check_field("command", 16'(want_res.command), 16'(got_res.command));
               check_field("length", 16'(want_res.length), 16'(got_res.length));
               check_field("payload_valid", 16'(want_res.pay_valid),
                           16'(got_res.pay_valid));
               check_field("payload_byte", 16'(want_res.pay_byte), 16'(got_res.pay_byte));
               check_field("payload_index", 16'(want_res.pay_index),
                           16'(got_res.pay_index));
               check_field("computed_crc", want_res.crc_comp, got_res.crc_comp);
               check_field("received_crc", want_res.crc_rcvd, got_res.crc_rcvd);
            end
            if (got_res.status == STATUS_DONE) begin
               good_frames++;
            end
            if (got_res.status == STATUS_ERR) begin
               err_reports++;
            end
            if (got_res.pay_valid) begin
               payload_beats++;
            end
         end
         if (hold_left > 0) begin
            ready_next = 1'b0;
         end else begin
            ready_next = $urandom_range(99) >= recv_stall_pct;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: hunting noise, zero length, start byte inside a frame, bad CRC
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      push_frame(8'hFF, 0, 1'b0, -1, -1);
      push_frame(8'h7E, 2, 1'b0, 8'h7E, -1);
      push_frame(8'h00, 1, 1'b1, -1, -1);
      drain();

      // too many payload bytes, then random with sender gaps
      phase_num = 1;
      csr_write(ADDR_MAX_PAYLOAD, 8'd0);
      send_idle_pct = 45;
      push_frame(8'h55, 1, 1'b0, -1, -1);
      gen_link_traffic(150);
      drain();

      phase_num = 2;
      csr_write(ADDR_START_BYTE, 8'h00);
      csr_write(ADDR_MAX_PAYLOAD, 8'd255);
      send_idle_pct  = 0;
      recv_stall_pct = 45;
      push_frame(8'($urandom), 255, 1'b0, -1, -1);
      gen_link_traffic(350);
      drain();

      phase_num = 3;
      csr_write(ADDR_START_BYTE, 8'hFF);
      csr_write(ADDR_MAX_PAYLOAD, 8'd8);
      send_idle_pct  = 22;
      recv_stall_pct = 22;
      gen_link_traffic(400);
      drain();

      csr_write(ADDR_START_BYTE, 8'($urandom_range(1, 254)));
      csr_write(ADDR_MAX_PAYLOAD, 8'($urandom_range(4, 20)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      gen_link_traffic(400);
      phase_num = PRESSURE_PHASE;
      drain();

      phase_num = 5;
      csr_write(ADDR_START_BYTE, START_BYTE_RESET);
      csr_write(ADDR_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
      send_idle_pct  = 22;
      recv_stall_pct = 22;
      gen_link_traffic(300);
      drain();
      repeat (8) @(posedge clock);

      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      end
      $display("Covered %0d byte beats over 6 register settings with gaps and back-pressure",
               beats_sent);
      $display("Saw %0d good frames, %0d error reports, %0d forwarded payload bytes",
               good_frames, err_reports, payload_beats);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/fpr_pkg.sv
hdl/fpr_parser.sv
hdl/fpr_out_buf.sv
hdl/framed_packet_receiver_crc16.sv
dv/framed_packet_receiver_crc16_tb.sv
